/* design/bitmap_page_allocator_defines.svh */
// Assertion macros shared by the allocator checker
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle
`define BPA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/bpa_pkg.sv */
// Shared types and codes of the bitmap page allocator
`default_nettype none
package bpa_pkg;
  localparam logic [1:0] MODE_ALLOC      = 2'd0;
  localparam logic [1:0] MODE_FREE_PAGE  = 2'd1;
  localparam logic [1:0] MODE_RESERVE    = 2'd2;
  localparam logic [1:0] MODE_FREE_RANGE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_PAGE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [2:0] REG_TOTAL  = 3'd0;
  localparam logic [2:0] REG_LOWRES = 3'd1;
  localparam logic [2:0] REG_HA_S   = 3'd2;
  localparam logic [2:0] REG_HA_E   = 3'd3;
  localparam logic [2:0] REG_HB_S   = 3'd4;
  localparam logic [2:0] REG_HB_E   = 3'd5;

  localparam int WORD_BITS = 64;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the request and derive the page range
    logic rd;        // issue a map read for the current word
    logic wr;        // apply the update to the word just read
    logic done_ld;   // build the result
  } bpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_empty; // no page left in the walk
    logic found;       // alloc hit in the word just read
  } bpa_sts_t;
endpackage
`default_nettype wire

/* design/bpa_if.sv */
// Valid/ready channel interfaces for requests and results
`default_nettype none
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [31:0] length;
  modport source (output valid, mode, address, length, input ready);
  modport sink (input valid, mode, address, length, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] page_address;
  logic [15:0] free_count;
  modport source (output valid, status, page_address, free_count, input ready);
  modport sink (input valid, status, page_address, free_count, output ready);
endinterface
`default_nettype wire

/* design/bpa_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/bpa_ctrl.sv */
// Sequencer for request intake, map word walk and result hand-off
`default_nettype none
module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     clr_busy,
  input  wire logic     is_alloc,
  input  wire bpa_sts_t sts,
  output bpa_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  // Accept a new transfer only when idle, no result is pending and the clearing pass is over
  assign in_ready  = (state_r == S_IDLE) && !ov_r && !clr_busy;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.range_empty) state_nxt = S_FIN;
        else state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_WR;
      S_WR: begin
        cmd.wr = 1'b1;
        if (is_alloc && sts.found) state_nxt = S_FIN;
        else state_nxt = S_CHK;
      end
      S_FIN: begin
        cmd.done_ld = 1'b1;
        ov_nxt      = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

/* design/bpa_dp.sv */
// Datapath: range setup, map word read-modify-write, free count
`default_nettype none
module bpa_dp
  import bpa_pkg::*;
#(
  parameter int PAGES      = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bpa_cmd_t    cmd,
  output bpa_sts_t         sts,
  output logic             clr_busy,
  output logic             is_alloc,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_length,
  input  wire logic [15:0] total_pages,
  input  wire logic [15:0] low_reserved_pages,
  input  wire logic [31:0] hole_a_start,
  input  wire logic [31:0] hole_a_end,
  input  wire logic [31:0] hole_b_start,
  input  wire logic [31:0] hole_b_end,
  output logic [1:0]       out_status,
  output logic [31:0]      out_page_address,
  output logic [15:0]      out_free_count
);
  localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SH    = $clog2(PAGE_BYTES);
  localparam int PW    = $clog2(PAGES) + 2;  // page index with headroom
  localparam int CW    = $clog2(WORDS + 1);
  localparam int BW    = 7;                  // bit count of one word, 0..64
  localparam logic [PW-1:0] PAGES_W = PW'(PAGES);

  logic [1:0]    mode_r;
  logic [PW-1:0] cur_r, last_r, cur_nxt;
  logic [15:0]   cnt_r;
  logic [1:0]    st_r;
  logic [31:0]   pa_r;
  logic          hit_r;
  logic [PW-1:0] hit_p_r;
  logic [CW-1:0] clr_r;
  logic [63:0]   rdata, wdata, mask, chg;
  logic [BW-1:0] nchg;
  logic          we;
  logic [WA-1:0] waddr;

  // Page range from the request, with 33-bit ends
  logic [32:0] a33, e33, fr_first, fr_last, rs_last;
  logic [PW-1:0] lim;
  logic [PW-1:0] f_sel, l_sel;
  always_comb begin
    a33      = {1'b0, in_address};
    e33      = a33 + {1'b0, in_length};
    rs_last  = 33'((34'(e33) + 34'(PAGE_BYTES - 1)) >> SH);
    fr_first = (a33 + 33'(PAGE_BYTES - 1)) >> SH;
    fr_last  = e33 >> SH;
    lim      = ({2'b0, total_pages} < PAGES_W) ? PW'(total_pages) : PAGES_W;
    f_sel    = PW'(a33 >> SH);
    l_sel    = lim;
    case (in_mode)
      MODE_ALLOC: begin
        f_sel = '0;
      end
      MODE_FREE_PAGE: begin
        if ((a33 >> SH) < 33'(lim)) l_sel = PW'(a33 >> SH) + PW'(1);
        else l_sel = f_sel;
      end
      MODE_RESERVE: begin
        if (rs_last < 33'(lim)) l_sel = PW'(rs_last);
        if ((a33 >> SH) > 33'(lim)) f_sel = lim;
      end
      default: begin
        f_sel = (fr_first < 33'(low_reserved_pages)) ? PW'(low_reserved_pages)
                                                    : PW'(fr_first);
        if (fr_last < 33'(lim)) l_sel = PW'(fr_last);
        if (fr_first > 33'(PAGES_W)) f_sel = PAGES_W;
      end
    endcase
  end

  assign is_alloc        = (mode_r == MODE_ALLOC);
  assign sts.range_empty = (cur_r >= last_r) || (is_alloc && cnt_r == 16'd0);

  // Per-bit mask of the current word: pages in [cur, last), skip windows in free-range mode
  logic [PW-1:0] wbase;
  assign wbase = {cur_r[PW-1:6], 6'd0};
  always_comb begin
    logic [PW-1:0] p;
    logic [47:0]   ba;
    for (int i = 0; i < WORD_BITS; i++) begin
      p  = wbase + PW'(i);
      ba = 48'(p) << SH;
      mask[i] = (p >= cur_r) && (p < last_r);
      if (mode_r == MODE_FREE_RANGE) begin
        if (ba >= 48'(hole_a_start) && ba < 48'(hole_a_end)) mask[i] = 1'b0;
        if (ba >= 48'(hole_b_start) && ba < 48'(hole_b_end)) mask[i] = 1'b0;
      end
    end
  end

  // Bits that change, lowest free bit for allocate
  logic [63:0] cand;
  logic [5:0]  low_idx;
  logic        any;
  always_comb begin
    cand    = ~rdata & mask;
    any     = |cand;
    low_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) if (cand[i]) low_idx = 6'(i);
    case (mode_r)
      MODE_ALLOC:      chg = any ? (64'd1 << low_idx) : 64'd0;
      MODE_RESERVE:    chg = cand;
      default:         chg = rdata & mask;
    endcase
    nchg = BW'($countones(chg));
    wdata = (mode_r == MODE_ALLOC || mode_r == MODE_RESERVE) ? (rdata | chg)
                                                            : (rdata & ~chg);
  end
  assign sts.found = any;

  // Next word start
  assign cur_nxt = wbase + PW'(WORD_BITS);

  assign clr_busy = (clr_r != CW'(WORDS));
  assign we    = clr_busy || cmd.wr;
  assign waddr = clr_busy ? WA'(clr_r) : WA'(cur_r >> 6);

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (clr_busy ? {WORD_BITS{1'b1}} : wdata),
    .raddr (WA'(cur_r >> 6)),
    .rdata (rdata)
  );

  // Clearing pass, request state, count and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (clr_busy) clr_r <= clr_r + CW'(1);
      if (cmd.wr) begin
        if (mode_r == MODE_ALLOC || mode_r == MODE_RESERVE)
          cnt_r <= cnt_r - 16'(nchg);
        else cnt_r <= cnt_r + 16'(nchg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      cur_r  <= f_sel;
      last_r <= l_sel;
      hit_r  <= 1'b0;
    end
    if (cmd.wr) begin
      cur_r <= cur_nxt;
      if (mode_r == MODE_ALLOC && any) begin
        hit_r   <= 1'b1;
        hit_p_r <= wbase + PW'(low_idx);
      end
      if (mode_r == MODE_FREE_PAGE && nchg != '0) hit_r <= 1'b1;
    end
    if (cmd.done_ld) begin
      pa_r <= 32'd0;
      st_r <= ST_DONE;
      if (mode_r == MODE_ALLOC) begin
        if (hit_r) pa_r <= 32'(64'(hit_p_r) << SH);
        else st_r <= ST_NO_PAGE;
      end else if (mode_r == MODE_FREE_PAGE && !hit_r) st_r <= ST_IGNORED;
    end
  end

  assign out_status       = st_r;
  assign out_page_address = pa_r;
  assign out_free_count   = cnt_r;
endmodule
`default_nettype wire

/* design/bitmap_page_allocator.sv */
// Top level of the first-fit bitmap page allocator
// Each request walks the map word by word (states CHK, RD, WAIT, WR per word,
// then FIN); allocate stops at the first word with a free page, range modes
// visit every word in range. One request at a time; the next is taken the
// cycle after the result transfer. Reset: synchronous active low; a clearing
// pass writes every map word and marks every page used, requests wait until
// it ends.
`default_nettype none
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGES      = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bpa_req_if.sink          in_ch,
  bpa_rsp_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [15:0] total_r, lowres_r;
  logic [31:0] has_r, hae_r, hbs_r, hbe_r;
  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic clr_busy, is_alloc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= 16'd32768;
      lowres_r <= 16'd256;
      has_r <= '0; hae_r <= '0; hbs_r <= '0; hbe_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL:  total_r  <= cfg_data[15:0];
        REG_LOWRES: lowres_r <= cfg_data[15:0];
        REG_HA_S:   has_r    <= cfg_data;
        REG_HA_E:   hae_r    <= cfg_data;
        REG_HB_S:   hbs_r    <= cfg_data;
        REG_HB_E:   hbe_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .clr_busy(clr_busy),
    .is_alloc(is_alloc), .sts(sts), .cmd(cmd)
  );

  bpa_dp #(.PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .clr_busy(clr_busy),
    .is_alloc(is_alloc), .in_mode(in_ch.mode), .in_address(in_ch.address),
    .in_length(in_ch.length), .total_pages(total_r),
    .low_reserved_pages(lowres_r), .hole_a_start(has_r), .hole_a_end(hae_r),
    .hole_b_start(hbs_r), .hole_b_end(hbe_r), .out_status(out_ch.status),
    .out_page_address(out_ch.page_address), .out_free_count(out_ch.free_count)
  );
endmodule
`default_nettype wire

/* design/bpa_checker.sv */
// Port-level checker for the allocator, bound to the top level
`default_nettype none
`include "bitmap_page_allocator_defines.svh"
module bpa_checker
  import bpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] page_address
);
  `BPA_ASSERT_IMP(a_no_accept_pending, clk, rst_n, out_valid, !in_ready)
  `BPA_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, status <= ST_IGNORED)
  `BPA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && status != ST_DONE,
                  page_address == 32'd0)
  `BPA_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(status))
endmodule

bind bitmap_page_allocator bpa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .page_address(out_ch.page_address)
);
`default_nettype wire

/* verif/bitmap_page_allocator_tb.sv */
// Self-checking testbench for the first-fit bitmap page allocator
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NPAGES    = 32768;
  localparam int PG_BYTES  = 4096;
  localparam int LATENCY   = 40;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page_address;
    logic [15:0] free_count;
  } alloc_result_t;

  // Page map predictor plus the queue of results it has worked out
  class alloc_scoreboard;
    bit            used [NPAGES];
    int            free_cnt;
    int unsigned   total_pages, low_res;
    longint        ha_s, ha_e, hb_s, hb_e;
    alloc_result_t pending_q [$];
    int            errors;

    function new();
      foreach (used[i]) used[i] = 1'b1;
      free_cnt    = 0;
      total_pages = 32768;
      low_res     = 256;
      ha_s = 0; ha_e = 0; hb_s = 0; hb_e = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_TOTAL:  total_pages = data[15:0];
        REG_LOWRES: low_res     = data[15:0];
        REG_HA_S:   ha_s        = data;
        REG_HA_E:   ha_e        = data;
        REG_HB_S:   hb_s        = data;
        REG_HB_E:   hb_e        = data;
        default: ;
      endcase
    endfunction

    function int unsigned limit();
      return (total_pages < NPAGES) ? total_pages : NPAGES;
    endfunction

    // Apply one accepted request to the map and queue its result
    function void note_request(logic [1:0] mode, logic [31:0] addr, logic [31:0] len);
      alloc_result_t r;
      longint lim, p, first, last, a;
      lim = limit();
      r.status       = ST_DONE;
      r.page_address = '0;
      case (mode)
        MODE_ALLOC: begin
          r.status = ST_NO_PAGE;
          if (free_cnt != 0) begin
            for (p = 0; p < lim; p++) begin
              if (!used[p]) begin
                used[p] = 1'b1;
                free_cnt--;
                r.page_address = p * PG_BYTES;
                r.status = ST_DONE;
                break;
              end
            end
          end
        end
        MODE_FREE_PAGE: begin
          p = longint'(addr) / PG_BYTES;
          if (p < lim && used[p]) begin
            used[p] = 1'b0;
            free_cnt++;
          end else begin
            r.status = ST_IGNORED;
          end
        end
        MODE_RESERVE: begin
          first = longint'(addr) / PG_BYTES;
          last  = (longint'(addr) + longint'(len) + PG_BYTES - 1) / PG_BYTES;
          if (last > lim) last = lim;
          for (p = first; p < last; p++) begin
            if (!used[p]) begin
              used[p] = 1'b1;
              free_cnt--;
            end
          end
        end
        default: begin
          first = (longint'(addr) + PG_BYTES - 1) / PG_BYTES;
          last  = (longint'(addr) + longint'(len)) / PG_BYTES;
          if (first < low_res) first = low_res;
          if (last > lim) last = lim;
          for (p = first; p < last; p++) begin
            a = p * PG_BYTES;
            if (a >= ha_s && a < ha_e) continue;
            if (a >= hb_s && a < hb_e) continue;
            if (used[p]) begin
              used[p] = 1'b0;
              free_cnt++;
            end
          end
        end
      endcase
      r.free_count = free_cnt[15:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: status=%0d addr=%h count=%0d",
                   $realtime, got.status, got.page_address, got.free_count);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status || got.page_address !== exp_r.page_address ||
          got.free_count !== exp_r.free_count) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp status=%0d addr=%h count=%0d got status=%0d addr=%h count=%0d",
                   $realtime, exp_r.status, exp_r.page_address, exp_r.free_count,
                   got.status, got.page_address, got.free_count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  bit          idling;
  bit          hold_request;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  alloc_scoreboard sb = new();

  bitmap_page_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req),
    .out_ch    (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels for transfers
  always @(posedge clk) begin
    if (rst_n && req.valid && req.ready)
      sb.note_request(req.mode, req.address, req.length);
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready)
      sb.check_result({rsp.status, rsp.page_address, rsp.free_count});
  end

  // Result side: random stall bursts and one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] mode, logic [31:0] addr, logic [31:0] len);
    if (idling && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.mode    <= mode;
    req.address <= addr;
    req.length  <= len;
    do @(posedge clk); while (!req.ready);
  endtask

  // Let the block settle, then load all six registers
  task automatic load_regs(logic [31:0] total, logic [31:0] lowres, logic [31:0] as,
                           logic [31:0] ae, logic [31:0] bs, logic [31:0] be);
    logic [31:0] vals [6];
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    vals = '{total, lowres, as, ae, bs, be};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      sb.write_reg(i[2:0], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_hole_edge(int unsigned lim);
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, lim * PG_BYTES + PG_BYTES);
    endcase
  endfunction

  // Mostly requests inside the managed range, some full-width noise
  task automatic send_random(int unsigned lim);
    logic [1:0]  mode;
    logic [31:0] addr, len;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      mode = MODE_ALLOC;
    else if (sel < 60) mode = MODE_FREE_PAGE;
    else if (sel < 75) mode = MODE_RESERVE;
    else               mode = MODE_FREE_RANGE;
    if ($urandom_range(0, 99) < 85) begin
      addr = (lim == 0) ? $urandom_range(0, 4 * PG_BYTES) :
             $urandom_range(0, lim * PG_BYTES - 1);
      len  = ($urandom_range(0, 9) == 0) ? lim * PG_BYTES :
             $urandom_range(0, 24 * PG_BYTES);
    end else begin
      addr = $urandom;
      len  = $urandom;
    end
    send(mode, addr, len);
  endtask

  initial begin
    int unsigned total, lim, lowres, nitems;
    logic [31:0] as, bs;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    req.valid   = 1'b0;
    req.mode    = MODE_ALLOC;
    req.address = '0;
    req.length  = '0;
    idling       = 1'b1;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, empty map, edges of every field
    send(MODE_ALLOC,      32'h0,         32'h0);
    send(MODE_FREE_PAGE,  32'h0,         32'h0);
    send(MODE_FREE_PAGE,  32'h0,         32'hFFFF_FFFF);
    send(MODE_FREE_PAGE,  32'hFFFF_FFFF, 32'h0);
    send(MODE_ALLOC,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_FREE_RANGE, 32'h0010_0FFF, 32'h0000_3001);
    send(MODE_RESERVE,    32'h0,         32'h0);
    send(MODE_FREE_RANGE, 32'h0020_0000, 32'h0);
    send(MODE_FREE_RANGE, 32'h0,         32'hFFFF_FFFF);
    send(MODE_ALLOC,      32'h0,         32'h0);
    send(MODE_ALLOC,      32'h0,         32'h0);
    send(MODE_RESERVE,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_FREE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_RESERVE,    32'h0010_0000, 32'h0001_0000);
    send(MODE_FREE_PAGE,  32'h0010_0ABC, 32'h0);
    send(MODE_FREE_RANGE, 32'hFFFF_F000, 32'h0000_1000);
    send(MODE_FREE_PAGE,  32'h07FF_FFFF, 32'h0);
    send(MODE_ALLOC,      32'h0,         32'h0);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 0) begin
        total = 65535; lowres = 0;
      end else if (ph == 1) begin
        total = 0; lowres = 65535;
      end else if (ph == 2) begin
        total = 1; lowres = 0;
      end else begin
        total  = $urandom_range(1, 4096);
        lowres = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, total);
      end
      lim = (total < NPAGES) ? total : NPAGES;
      as  = pick_hole_edge(lim);
      bs  = pick_hole_edge(lim);
      load_regs(total, lowres, as,
                ($urandom_range(0, 4) == 0) ? pick_hole_edge(lim) :
                  as + $urandom_range(0, 16 * PG_BYTES),
                bs,
                ($urandom_range(0, 4) == 0) ? pick_hole_edge(lim) :
                  bs + $urandom_range(0, 16 * PG_BYTES));
      if (ph == 12) idling = 1'b0;
      nitems = (ph < 2) ? 30 : 110;
      for (int i = 0; i < nitems; i++) begin
        if (ph == 4 && i == 10) hold_request = 1'b1;
        send_random(lim);
      end
    end

    // Drain, then report
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bitmap_page_allocator_tb: PASS");
    end else begin
      $display("bitmap_page_allocator_tb: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #40ms;
    $display("bitmap_page_allocator_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/bpa_pkg.sv
design/bpa_if.sv
design/bpa_ram.sv
design/bpa_ctrl.sv
design/bpa_dp.sv
design/bitmap_page_allocator.sv
design/bpa_checker.sv
verif/bitmap_page_allocator_tb.sv
